/* sv/expansion_port_shadow_controller_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the expansion-port shadow controller
// Shared concurrent-assertion forms, clocked and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef EXPANSION_PORT_SHADOW_CONTROLLER_ASSERT_SVH
`define EXPANSION_PORT_SHADOW_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define EPSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("epsc assertion failed");

// next-cycle implication
`define EPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("epsc assertion failed");

`endif

/* sv/epsc_pkg.sv */
// ---------------------------------------------------------------------------
// epsc_pkg
// Command codes, image constants and the decoded command type.
// ---------------------------------------------------------------------------
`default_nettype none

package epsc_pkg;

	// command codes
	localparam logic [4:0] MODE_INIT      = 5'd0;
	localparam logic [4:0] MODE_DECK      = 5'd1;
	localparam logic [4:0] MODE_DECK_CLR  = 5'd2;
	localparam logic [4:0] MODE_BAR_POS   = 5'd3;
	localparam logic [4:0] MODE_BAR_PCT   = 5'd4;
	localparam logic [4:0] MODE_BAR_BIN   = 5'd5;
	localparam logic [4:0] MODE_HEADLIGHT = 5'd6;
	localparam logic [4:0] MODE_LOAD      = 5'd7;
	localparam logic [4:0] MODE_EN_SERVO  = 5'd8;
	localparam logic [4:0] MODE_EN_IR     = 5'd9;
	localparam logic [4:0] MODE_EN_MAG    = 5'd10;
	localparam logic [4:0] MODE_EN_ACCEL  = 5'd11;
	localparam logic [4:0] MODE_EN_5V     = 5'd12;
	localparam logic [4:0] MODE_MAG_RST   = 5'd13;
	localparam logic [4:0] MODE_RFID_RST  = 5'd14;
	localparam logic [4:0] MODE_NOOP      = 5'd15;

	// deck light sub-commands
	localparam logic [9:0] DECK_OFF    = 10'd1;
	localparam logic [9:0] DECK_TOGGLE = 10'd2;
	localparam logic [9:0] ARG_ENABLE  = 10'd1;

	// image constants
	localparam logic [31:0] IMAGE_RESET = 32'h3400_0000;
	localparam logic [7:0]  DECK_KEEP   = 8'h03;
	localparam logic [7:0]  BAR_LOW_CLR = 8'hFC;

	// bit positions in the image
	localparam logic [4:0] BIT_DECK0   = 5'd18;
	localparam logic [4:0] BIT_SERVO   = 5'd31;
	localparam logic [4:0] BIT_IR      = 5'd30;
	localparam logic [4:0] BIT_RFID    = 5'd29;
	localparam logic [4:0] BIT_MAG_EN  = 5'd27;
	localparam logic [4:0] BIT_MAG_RST = 5'd26;
	localparam logic [4:0] BIT_ACCEL   = 5'd25;
	localparam logic [4:0] BIT_5V      = 5'd24;

	// command queue depth
	localparam int QUEUE_DEPTH = 4;

	// what the back end does with a command
	typedef enum logic [1:0] {
		K_NONE,   // update image only
		K_EMIT,   // update image, emit frame
		K_ERROR,  // emit frame with invalid status
		K_PULSE   // two frames: bit cleared, then set
	} kind_t;

	// decoded command: image' = ((image & and_m) | or_m) ^ xor_m
	// for a pulse, and_m clears the bit and or_m sets it again
	typedef struct packed {
		kind_t       kind;
		logic [31:0] and_m;
		logic [31:0] or_m;
		logic [31:0] xor_m;
	} cmd_t;

	// queue head as seen by the back end
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} head_t;

endpackage

`default_nettype wire

/* sv/epsc_front.sv */
// ---------------------------------------------------------------------------
// epsc_front
// Classifies one command into a kind and a set of image masks.
// ---------------------------------------------------------------------------
`default_nettype none

module epsc_front (
	input  wire logic [4:0] mode,
	input  wire logic [2:0] light_index,
	input  wire logic [9:0] arg,
	input  wire logic [1:0] position,
	input  wire logic [2:0] color,
	output epsc_pkg::cmd_t  cmd
);
	import epsc_pkg::*;

	logic [4:0] bit_idx;
	logic [7:0] bar_low;
	logic [1:0] bar_high;
	logic [2:0] p1;
	logic       col_a;
	logic       col_b;
	logic       en_on;

	// headlight corner to the first bit of its pair in byte0
	always_comb begin
		case (position)
			2'd0:    p1 = 3'd2;
			2'd1:    p1 = 3'd0;
			2'd2:    p1 = 3'd6;
			default: p1 = 3'd4;
		endcase
	end

	assign col_a = (color == 3'd1) || (color == 3'd2);
	assign col_b = (color == 3'd2) || (color == 3'd3);
	assign en_on = (arg == ARG_ENABLE);

	// bar segment pattern
	always_comb begin
		bar_low  = 8'h00;
		bar_high = 2'b00;
		case (mode)
			MODE_BAR_POS: begin
				if (arg <= 10'd7) begin
					bar_low = 8'h01 << arg[2:0];
				end else if (arg == 10'd8) begin
					bar_high = 2'b01;
				end else begin
					bar_high = 2'b10;
				end
			end
			MODE_BAR_PCT: begin
				if (arg <= 10'd8) begin
					bar_low = 8'((9'd1 << arg[3:0]) - 9'd1);
				end else if (arg == 10'd9) begin
					bar_low  = 8'hFF;
					bar_high = 2'b01;
				end else begin
					bar_low  = 8'hFF;
					bar_high = 2'b11;
				end
			end
			default: begin
				bar_low  = arg[7:0];
				bar_high = arg[9:8];
			end
		endcase
	end

	// deck light bit, only meaningful for index 0..5
	assign bit_idx = BIT_DECK0 + {2'b00, light_index};

	// mask generation
	always_comb begin
		cmd.kind  = K_NONE;
		cmd.and_m = '1;
		cmd.or_m  = '0;
		cmd.xor_m = '0;
		case (mode)
			MODE_INIT: begin
				cmd.kind  = K_EMIT;
				cmd.and_m = '0;
				cmd.or_m  = IMAGE_RESET;
			end
			MODE_DECK: begin
				if (light_index <= 3'd5) begin
					if (arg == DECK_OFF) begin
						cmd.and_m[bit_idx] = 1'b0;
					end else if (arg == DECK_TOGGLE) begin
						cmd.xor_m[bit_idx] = 1'b1;
					end else begin
						cmd.or_m[bit_idx] = 1'b1;
					end
				end
			end
			MODE_DECK_CLR: begin
				cmd.and_m[23:16] = DECK_KEEP;
			end
			MODE_BAR_POS, MODE_BAR_PCT, MODE_BAR_BIN: begin
				cmd.and_m[15:8]  = 8'h00;
				cmd.and_m[23:16] = BAR_LOW_CLR;
				cmd.or_m[15:8]   = bar_low;
				cmd.or_m[17:16]  = bar_high;
			end
			MODE_HEADLIGHT: begin
				cmd.and_m[p1]        = 1'b0;
				cmd.and_m[p1 + 3'd1] = 1'b0;
				cmd.or_m[p1]         = col_a;
				cmd.or_m[p1 + 3'd1]  = col_b;
			end
			MODE_LOAD: begin
				cmd.kind = K_EMIT;
			end
			MODE_EN_SERVO: begin
				cmd.and_m[BIT_SERVO] = 1'b0;
				cmd.or_m[BIT_SERVO]  = en_on;
			end
			MODE_EN_IR: begin
				cmd.and_m[BIT_IR] = 1'b0;
				cmd.or_m[BIT_IR]  = en_on;
			end
			MODE_EN_MAG: begin
				cmd.and_m[BIT_MAG_EN] = 1'b0;
				cmd.or_m[BIT_MAG_EN]  = en_on;
			end
			MODE_EN_ACCEL: begin
				cmd.and_m[BIT_ACCEL] = 1'b0;
				cmd.or_m[BIT_ACCEL]  = en_on;
			end
			MODE_EN_5V: begin
				// active low supply enable
				cmd.and_m[BIT_5V] = 1'b0;
				cmd.or_m[BIT_5V]  = !en_on;
			end
			MODE_MAG_RST: begin
				cmd.kind                = K_PULSE;
				cmd.and_m[BIT_MAG_RST]  = 1'b0;
				cmd.or_m[BIT_MAG_RST]   = 1'b1;
			end
			MODE_RFID_RST: begin
				cmd.kind             = K_PULSE;
				cmd.and_m[BIT_RFID]  = 1'b0;
				cmd.or_m[BIT_RFID]   = 1'b1;
			end
			MODE_NOOP: begin
				cmd.kind = K_NONE;
			end
			default: begin
				cmd.kind = K_ERROR;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/epsc_queue.sv */
// ---------------------------------------------------------------------------
// epsc_queue
// Short FIFO of decoded commands between the front and back ends.
// ---------------------------------------------------------------------------
`default_nettype none

module epsc_queue #(
	parameter int DEPTH = epsc_pkg::QUEUE_DEPTH
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  epsc_pkg::cmd_t wr_cmd,
	output logic           full,
	input  wire logic      pop,
	output epsc_pkg::head_t head
);
	import epsc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.cmd   = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/epsc_back.sv */
// ---------------------------------------------------------------------------
// epsc_back
// Applies queued commands to the shadow image and registers result frames.
// ---------------------------------------------------------------------------
`default_nettype none

module epsc_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  epsc_pkg::head_t  head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      frame,
	output logic             status,
	output logic             last
);
	import epsc_pkg::*;

	typedef enum logic {
		PH_FIRST,
		PH_SECOND
	} phase_t;

	phase_t      phase_q;
	logic [31:0] image_q;
	logic        out_valid_q;
	logic [31:0] frame_q;
	logic        status_q;
	logic        last_q;

	logic        out_free;
	logic        emits;
	logic        fire;
	logic        pulse_first;
	logic [31:0] next_image;

	assign out_free    = !out_valid_q || !out_stall;
	assign emits       = (head.cmd.kind != K_NONE);
	assign fire        = head.valid && (!emits || out_free);
	assign pulse_first = (head.cmd.kind == K_PULSE) && (phase_q == PH_FIRST);
	// a pulse keeps its queue slot until its second frame
	assign pop         = fire && !pulse_first;

	// read-modify-write of the image; first pulse frame only clears
	assign next_image = ((image_q & head.cmd.and_m) | (pulse_first ? '0 : head.cmd.or_m))
		^ head.cmd.xor_m;

	// image, pulse phase and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FIRST;
			image_q     <= IMAGE_RESET;
			out_valid_q <= 1'b0;
			frame_q     <= '0;
			status_q    <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (fire) begin
				image_q <= next_image;
				if (head.cmd.kind == K_PULSE) begin
					phase_q <= pulse_first ? PH_SECOND : PH_FIRST;
				end
			end
			if (fire && emits) begin
				out_valid_q <= 1'b1;
				frame_q     <= next_image;
				status_q    <= (head.cmd.kind == K_ERROR);
				last_q      <= !pulse_first;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign frame     = frame_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire

/* sv/expansion_port_shadow_controller.sv */
// ---------------------------------------------------------------------------
// expansion_port_shadow_controller
// Shadow image of the expansion-port shift-register chain, one command per
// transaction, frames out on a valid/stall channel.
// ---------------------------------------------------------------------------
// The block accepts one command per clock while its command queue has room
// and emits frames at one per clock while the output does not stall. A
// command is decoded combinationally into image masks and written to a
// QUEUE_DEPTH-entry queue; the back end retires one queued command per
// cycle, unless the output stalls or a pulse holds the head, by a
// read-modify-write of the 32-bit image. Init, load and invalid commands
// give one frame; magnetometer and RFID reset pulses hold the queue head
// until their second frame and give two frames, the last flag set on the
// second. Silent commands never wait on the output side. Output is registered,
// so a stalled frame does not block intake until the queue fills.
`default_nettype none

module expansion_port_shadow_controller #(
	parameter int QUEUE_DEPTH = epsc_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  mode,
	input  wire logic [2:0]  light_index,
	input  wire logic [9:0]  arg,
	input  wire logic [1:0]  position,
	input  wire logic [2:0]  color,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      frame,
	output logic             status,
	output logic             last
);
	import epsc_pkg::*;

	cmd_t  dec_cmd;
	head_t q_head;
	logic  q_full;
	logic  q_pop;
	logic  q_push;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	// command decode
	epsc_front u_front (
		.mode        (mode),
		.light_index (light_index),
		.arg         (arg),
		.position    (position),
		.color       (color),
		.cmd         (dec_cmd)
	);

	// command queue
	epsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wr_cmd (dec_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.head   (q_head)
	);

	// image update and frame output
	epsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.frame     (frame),
		.status    (status),
		.last      (last)
	);

	// checks
`include "expansion_port_shadow_controller_assert.svh"

	// only a pulse gives a non-final frame, and it is never an error
	`EPSC_ASSERT_NOW(a_first_not_error, clk, arst_n, out_valid && !last, !status)

	// the first pulse frame has its reset bit low
	`EPSC_ASSERT_NOW(a_first_bit_low, clk, arst_n, out_valid && !last,
		!frame[BIT_MAG_RST] || !frame[BIT_RFID])

	// the second pulse frame follows right after the first is taken
	`EPSC_ASSERT_NEXT(a_second_follows, clk, arst_n, out_valid && !last && !out_stall,
		out_valid && last)

endmodule

`default_nettype wire

/* dv/epsc_frame_checker.sv */
// ---------------------------------------------------------------------------
// epsc_frame_checker
// Watches the command and frame channels of the shadow controller, keeps its
// own copy of the shadow image, works out the frames each accepted command
// must give and compares every accepted frame with the oldest one due.
// ---------------------------------------------------------------------------

module epsc_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [4:0]  mode,
	input  logic [2:0]  light_index,
	input  logic [9:0]  arg,
	input  logic [1:0]  position,
	input  logic [2:0]  color,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] frame,
	input  logic        status,
	input  logic        last,
	output int          fail_count,
	output int          frames_pending
);
	import epsc_pkg::*;

	// status codes on the frame channel
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	// headlight colours and corners
	localparam logic [2:0] COLOR_GREEN  = 3'd1;
	localparam logic [2:0] COLOR_ORANGE = 3'd2;
	localparam logic [2:0] COLOR_RED    = 3'd3;
	localparam logic [1:0] CORNER_FL = 2'd0;
	localparam logic [1:0] CORNER_FR = 2'd1;
	localparam logic [1:0] CORNER_BL = 2'd2;
	localparam logic [1:0] CORNER_BR = 2'd3;

	typedef struct packed {
		logic [31:0] frame;
		logic        status;
		logic        last;
	} frame_due_t;

	logic [31:0] image;
	frame_due_t  frames_due[$];

	initial begin
		fail_count     = 0;
		frames_pending = 0;
		image          = IMAGE_RESET;
	end

	// queue the current image as a frame that must come out
	task automatic queue_frame(input logic st, input logic lst);
		frame_due_t f;
		f.frame  = image;
		f.status = st;
		f.last   = lst;
		frames_due.push_back(f);
	endtask

	// bar: segments 0..7 in byte1, segments 8..9 in byte2 bits 0..1
	task automatic set_bar(input logic [7:0] low8, input logic [1:0] high2);
		image[15:8]  = low8;
		image[23:16] = (image[23:16] & BAR_LOW_CLR) | {6'd0, high2};
	endtask

	// one command: update the image, queue whatever frames it gives
	task automatic apply_command(input logic [4:0] m, input logic [2:0] li,
			input logic [9:0] a, input logic [1:0] p, input logic [2:0] c);
		logic [4:0] bitpos;
		logic [8:0] thermo;
		case (m)
			MODE_INIT: begin
				image = IMAGE_RESET;
				queue_frame(STATUS_OK, 1'b1);
			end
			MODE_DECK: begin
				// lights 6 and 7 do not exist
				if (li <= 3'd5) begin
					bitpos = BIT_DECK0 + 5'(li);
					if (a == DECK_OFF)
						image[bitpos] = 1'b0;
					else if (a == DECK_TOGGLE)
						image[bitpos] = ~image[bitpos];
					else
						image[bitpos] = 1'b1;
				end
			end
			MODE_DECK_CLR: image[23:16] = image[23:16] & DECK_KEEP;
			MODE_BAR_POS: begin
				if (a <= 10'd7)
					set_bar(8'd1 << a[2:0], 2'd0);
				else if (a == 10'd8)
					set_bar(8'd0, 2'd1);
				else
					set_bar(8'd0, 2'd2);
			end
			MODE_BAR_PCT: begin
				if (a <= 10'd8) begin
					thermo = (9'd1 << a[3:0]) - 9'd1;
					set_bar(thermo[7:0], 2'd0);
				end else if (a == 10'd9) begin
					set_bar(8'hFF, 2'd1);
				end else begin
					set_bar(8'hFF, 2'd3);
				end
			end
			MODE_BAR_BIN: set_bar(a[7:0], a[9:8]);
			MODE_HEADLIGHT: begin
				case (p)
					CORNER_FL: bitpos = 5'd2;
					CORNER_FR: bitpos = 5'd0;
					CORNER_BL: bitpos = 5'd6;
					CORNER_BR: bitpos = 5'd4;
					default:   bitpos = 5'd4;
				endcase
				// colours above red are black
				image[bitpos]        = (c == COLOR_GREEN) || (c == COLOR_ORANGE);
				image[bitpos + 5'd1] = (c == COLOR_ORANGE) || (c == COLOR_RED);
			end
			MODE_LOAD:     queue_frame(STATUS_OK, 1'b1);
			MODE_EN_SERVO: image[BIT_SERVO]  = (a == ARG_ENABLE);
			MODE_EN_IR:    image[BIT_IR]     = (a == ARG_ENABLE);
			MODE_EN_MAG:   image[BIT_MAG_EN] = (a == ARG_ENABLE);
			MODE_EN_ACCEL: image[BIT_ACCEL]  = (a == ARG_ENABLE);
			MODE_EN_5V:    image[BIT_5V]     = (a != ARG_ENABLE);
			MODE_MAG_RST, MODE_RFID_RST: begin
				bitpos = (m == MODE_MAG_RST) ? BIT_MAG_RST : BIT_RFID;
				image[bitpos] = 1'b0;
				queue_frame(STATUS_OK, 1'b0);
				image[bitpos] = 1'b1;
				queue_frame(STATUS_OK, 1'b1);
			end
			MODE_NOOP: ;
			default: queue_frame(STATUS_BAD, 1'b1);
		endcase
	endtask

	// compare an accepted frame with the oldest one due
	task automatic check_frame();
		frame_due_t f;
		if (frames_due.size() == 0) begin
			$error("frame %h with nothing due", frame);
			fail_count++;
		end else begin
			f = frames_due.pop_front();
			if (frame !== f.frame) begin
				$error("frame: expected %h, actual %h", f.frame, frame);
				fail_count++;
			end
			if (status !== f.status) begin
				$error("status: expected %b, actual %b", f.status, status);
				fail_count++;
			end
			if (last !== f.last) begin
				$error("last: expected %b, actual %b", f.last, last);
				fail_count++;
			end
		end
	endtask

	// a frame can never leave in the cycle its command enters, so the
	// output side is handled first
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image = IMAGE_RESET;
			frames_due.delete();
			frames_pending = 0;
		end else begin
			if (out_valid && !out_stall)
				check_frame();
			if (in_valid && !in_stall)
				apply_command(mode, light_index, arg, position, color);
			frames_pending = frames_due.size();
		end
	end

endmodule

/* dv/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Drives commands into the expansion-port shadow controller with random
// gaps and random frame-side stalls, one long frame-side hold-off to fill
// the command queue, and leaves prediction and comparison to the checker.
// ---------------------------------------------------------------------------

module tb_top;
	import epsc_pkg::*;

	localparam int RANDOM_CMDS = 800;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_START  = 600;
	localparam int HOLD_CYCLES = 300;
	localparam int TAIL_CYCLES = 10;

	// unused codes at both ends of the range
	localparam logic [4:0] MODE_UNUSED_LO = 5'd16;
	localparam logic [4:0] MODE_UNUSED_HI = 5'd31;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [4:0]  mode;
	logic [2:0]  light_index;
	logic [9:0]  arg;
	logic [1:0]  position;
	logic [2:0]  color;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] frame;
	logic        status;
	logic        last;
	int          fail_count;
	int          frames_pending;

	expansion_port_shadow_controller DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .light_index(light_index), .arg(arg),
		.position(position), .color(color),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame(frame), .status(status), .last(last)
	);

	epsc_frame_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .light_index(light_index), .arg(arg),
		.position(position), .color(color),
		.out_valid(out_valid), .out_stall(out_stall),
		.frame(frame), .status(status), .last(last),
		.fail_count(fail_count), .frames_pending(frames_pending)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)      return 0;
		else if (r < 85) return $urandom_range(1, 3);
		else if (r < 97) return $urandom_range(4, 10);
		else             return $urandom_range(20, 60);
	endfunction

	// offer one command after a gap and hold it until accepted
	task automatic issue_command(input int gap, input logic [4:0] m,
			input logic [2:0] li, input logic [9:0] a, input logic [1:0] p,
			input logic [2:0] c);
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid    <= 1'b1;
		mode        <= m;
		light_index <= li;
		arg         <= a;
		position    <= p;
		color       <= c;
		do @(posedge clk); while (in_stall);
	endtask

	// random command, weighted toward the defined codes
	task automatic issue_random(input int n);
		logic [4:0] m;
		logic [9:0] a;
		int         gap;
		if ($urandom_range(0, 99) < 75)
			m = 5'($urandom_range(0, 15));
		else
			m = 5'($urandom_range(16, 31));
		if ($urandom_range(0, 99) < 40)
			a = 10'($urandom_range(0, 11));
		else
			a = 10'($urandom_range(0, 1023));
		// back-to-back bursts now and then
		gap = ((n % 128) < 24) ? 0 : pick_gap();
		issue_command(gap, m, 3'($urandom_range(0, 7)), a, 2'($urandom_range(0, 3)),
			3'($urandom_range(0, 7)));
	endtask

	// frame side: random stall runs, one long hold-off to fill the queue
	initial begin
		int rx_cycles;
		int run_left;
		logic run_val;
		out_stall = 1'b0;
		rx_cycles = 0;
		run_left  = 0;
		run_val   = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			rx_cycles++;
			if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES) begin
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= run_val;
			end else begin
				run_val = ($urandom_range(0, 99) < 35);
				if (run_val)
					run_left = ($urandom_range(0, 99) < 95) ? $urandom_range(0, 3)
						: $urandom_range(30, 80);
				else
					run_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 15)
						: $urandom_range(60, 150);
				out_stall <= run_val;
			end
		end
	end

	// watchdog: ends the run when no transaction moves for too long
	initial begin
		int idle;
		idle = 0;
		wait (arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	// reset, directed commands, random commands, drain, verdict
	initial begin
		in_valid    = 1'b0;
		mode        = MODE_NOOP;
		light_index = 3'd0;
		arg         = 10'd0;
		position    = 2'd0;
		color       = 3'd0;
		arst_n      = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		issue_command(1, MODE_INIT,      3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_DECK,      3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_DECK,      3'd5, DECK_TOGGLE, 2'd0, 3'd0);
		// unknown deck sub-command turns the light on
		issue_command(0, MODE_DECK,      3'd3, 10'd1023, 2'd3, 3'd7);
		// light index out of range
		issue_command(0, MODE_DECK,      3'd7, DECK_TOGGLE, 2'd0, 3'd0);
		issue_command(0, MODE_LOAD,      3'd0, 10'd0,    2'd0, 3'd0);
		// bar position and percent past the top
		issue_command(0, MODE_BAR_POS,   3'd0, 10'd1023, 2'd0, 3'd0);
		issue_command(0, MODE_LOAD,      3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_BAR_PCT,   3'd0, 10'd9,    2'd0, 3'd0);
		issue_command(0, MODE_BAR_PCT,   3'd0, 10'd1023, 2'd0, 3'd0);
		issue_command(0, MODE_LOAD,      3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_BAR_BIN,   3'd0, 10'd1023, 2'd0, 3'd0);
		issue_command(0, MODE_HEADLIGHT, 3'd0, 10'd0,    2'd0, 3'd1);
		issue_command(0, MODE_HEADLIGHT, 3'd0, 10'd0,    2'd1, 3'd2);
		issue_command(0, MODE_HEADLIGHT, 3'd0, 10'd0,    2'd2, 3'd3);
		// colour above red is black
		issue_command(0, MODE_HEADLIGHT, 3'd0, 10'd0,    2'd3, 3'd7);
		issue_command(0, MODE_EN_SERVO,  3'd0, ARG_ENABLE, 2'd0, 3'd0);
		issue_command(0, MODE_EN_IR,     3'd0, ARG_ENABLE, 2'd0, 3'd0);
		issue_command(0, MODE_EN_MAG,    3'd0, 10'd1023, 2'd0, 3'd0);
		issue_command(0, MODE_EN_ACCEL,  3'd0, ARG_ENABLE, 2'd0, 3'd0);
		issue_command(0, MODE_EN_5V,     3'd0, ARG_ENABLE, 2'd0, 3'd0);
		issue_command(0, MODE_DECK_CLR,  3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_MAG_RST,   3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_RFID_RST,  3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_NOOP,      3'd7, 10'd1023, 2'd3, 3'd7);
		issue_command(0, MODE_UNUSED_LO, 3'd0, 10'd0,    2'd0, 3'd0);
		issue_command(0, MODE_UNUSED_HI, 3'd7, 10'd1023, 2'd3, 3'd7);

		for (int n = 0; n < RANDOM_CMDS; n++)
			issue_random(n);

		@(negedge clk);
		in_valid <= 1'b0;
		while (frames_pending != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/epsc_pkg.sv
sv/epsc_front.sv
sv/epsc_queue.sv
sv/epsc_back.sv
sv/expansion_port_shadow_controller.sv
dv/epsc_frame_checker.sv
dv/tb_top.sv
